>>> sv/sasf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sasf_pkg
// Types and constants shared by the snoop filter directory files.
// ----------------------------------------------------------------------------
package sasf_pkg;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned SH_W     = 7;
  localparam int unsigned OFS_W    = 4;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned WAY_O_W  = 3;

  localparam logic [OFS_W-1:0] OFS_RESET = 4'd6;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP  = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_SET_CNT = 2'd2,
    OP_RELEASE = 2'd3
  } sasf_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT          = 4'd0,
    ST_FILLED       = 4'd1,
    ST_VICTIM_HIT   = 4'd2,
    ST_MISS         = 4'd3,
    ST_EVICTED      = 4'd4,
    ST_UNTRACKED    = 4'd5,
    ST_VICTIM_FULL  = 4'd6,
    ST_REL_MISSING  = 4'd7,
    ST_RELEASED     = 4'd8,
    ST_UPDATED      = 4'd9,
    ST_UPD_MISSING  = 4'd10
  } sasf_status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } sasf_fsm_e;

  // Commands from the control path to the victim list
  typedef struct packed {
    logic              push;
    logic              upd;
    logic              rel;
    logic [ADDR_W-1:0] push_addr;
    logic [SH_W-1:0]   push_sh;
    logic [SH_W-1:0]   upd_sh;
  } sasf_vic_cmd_t;

  typedef struct packed {
    logic found;
    logic full;
  } sasf_vic_sts_t;

endpackage
`default_nettype wire

>>> sv/sasf_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sasf_req_if
// Request channel: operation, address, region flag and sharer count.
// ----------------------------------------------------------------------------
interface sasf_req_if;
  import sasf_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  logic              in_coherent_region;
  logic [SH_W-1:0]   sharer_count;

  modport source (output valid, operation, address, in_coherent_region, sharer_count,
                  input ready);
  modport sink   (input valid, operation, address, in_coherent_region, sharer_count,
                  output ready);
endinterface
`default_nettype wire

>>> sv/sasf_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sasf_rsp_if
// Response channel: status, way and evicted entry.
// ----------------------------------------------------------------------------
interface sasf_rsp_if;
  import sasf_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WAY_O_W-1:0]  way;
  logic [ADDR_W-1:0]   evicted_address;
  logic [SH_W-1:0]     evicted_sharers;

  modport source (output valid, status, way, evicted_address, evicted_sharers,
                  input ready);
  modport sink   (input valid, status, way, evicted_address, evicted_sharers,
                  output ready);
endinterface
`default_nettype wire

>>> sv/sasf_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sasf_cfg_if
// Configuration write channel carrying the block offset width.
// ----------------------------------------------------------------------------
interface sasf_cfg_if;
  import sasf_pkg::*;

  logic             valid;
  logic             ready;
  logic [OFS_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> sv/sasf_dir_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sasf_dir_mem
// Directory memory, one row per set holding all ways and the set's
// replacement pointer. Row valid flags make unwritten rows read as reset, but for the addresses.
// ----------------------------------------------------------------------------
module sasf_dir_mem #(
  parameter int unsigned WAYS  = 8,
  parameter int unsigned SETS  = 128,
  parameter int unsigned WAY_W = 3,
  parameter int unsigned SET_W = 7
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  rd_en_i,
  input  wire  [SET_W-1:0]                     rd_set_i,
  output logic [WAYS-1:0]                      rd_v_o,
  output logic [WAYS-1:0][sasf_pkg::ADDR_W-1:0] rd_a_o,
  output logic [WAYS-1:0][sasf_pkg::SH_W-1:0]   rd_s_o,
  output logic [WAY_W-1:0]                     rd_p_o,
  input  wire                                  wr_en_i,
  input  wire  [SET_W-1:0]                     wr_set_i,
  input  wire  [WAYS-1:0]                      wr_v_i,
  input  wire  [WAYS-1:0][sasf_pkg::ADDR_W-1:0] wr_a_i,
  input  wire  [WAYS-1:0][sasf_pkg::SH_W-1:0]   wr_s_i,
  input  wire  [WAY_W-1:0]                     wr_p_i
);
  import sasf_pkg::*;

  logic [WAYS-1:0]             mem_v [SETS];
  logic [WAYS-1:0][ADDR_W-1:0] mem_a [SETS];
  logic [WAYS-1:0][SH_W-1:0]   mem_s [SETS];
  logic [WAY_W-1:0]            mem_p [SETS];

  logic [SETS-1:0]             row_vld_q;
  logic                        rd_vld_q;
  logic [WAYS-1:0]             rd_v_q;
  logic [WAYS-1:0][ADDR_W-1:0] rd_a_q;
  logic [WAYS-1:0][SH_W-1:0]   rd_s_q;
  logic [WAY_W-1:0]            rd_p_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_v[wr_set_i] <= wr_v_i;
      mem_a[wr_set_i] <= wr_a_i;
      mem_s[wr_set_i] <= wr_s_i;
      mem_p[wr_set_i] <= wr_p_i;
    end
    if (rd_en_i) begin
      rd_v_q <= mem_v[rd_set_i];
      rd_a_q <= mem_a[rd_set_i];
      rd_s_q <= mem_s[rd_set_i];
      rd_p_q <= mem_p[rd_set_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_set_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_set_i];
      end
    end
  end

  assign rd_v_o = rd_vld_q ? rd_v_q : '0;
  assign rd_a_o = rd_a_q;
  assign rd_s_o = rd_vld_q ? rd_s_q : '0;
  assign rd_p_o = rd_vld_q ? rd_p_q : '0;

endmodule
`default_nettype wire

>>> sv/sasf_way_sel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sasf_way_sel
// Way selection for one set: address hit, first free way and the
// replacement candidate with the fewest sharers from the pointer onwards.
// ----------------------------------------------------------------------------
module sasf_way_sel #(
  parameter int unsigned WAYS  = 8,
  parameter int unsigned WAY_W = 3
) (
  input  wire  [WAYS-1:0]                       v_i,
  input  wire  [WAYS-1:0][sasf_pkg::ADDR_W-1:0] a_i,
  input  wire  [WAYS-1:0][sasf_pkg::SH_W-1:0]   s_i,
  input  wire  [WAY_W-1:0]                      ptr_i,
  input  wire  [sasf_pkg::ADDR_W-1:0]           addr_i,
  output logic                                  hit_o,
  output logic [WAY_W-1:0]                      hit_way_o,
  output logic                                  free_o,
  output logic [WAY_W-1:0]                      free_way_o,
  output logic [WAY_W-1:0]                      ev_way_o
);
  import sasf_pkg::*;

  always_comb begin
    logic [WAY_W:0]   idx;
    logic [SH_W-1:0]  best_sh;
    logic [WAY_W-1:0] best;
    hit_o      = 1'b0;
    hit_way_o  = '0;
    free_o     = 1'b0;
    free_way_o = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (v_i[w] && (a_i[w] == addr_i)) begin
        hit_o     = 1'b1;
        hit_way_o = WAY_W'(w);
      end
      if (!v_i[w]) begin
        free_o     = 1'b1;
        free_way_o = WAY_W'(w);
      end
    end
    // wrapped scan from the pointer, first minimum kept
    best    = ptr_i;
    best_sh = s_i[ptr_i];
    for (int k = 1; k < WAYS; k++) begin
      idx = {1'b0, ptr_i} + (WAY_W + 1)'(k);
      if (idx >= (WAY_W + 1)'(WAYS)) begin
        idx = idx - (WAY_W + 1)'(WAYS);
      end
      if (s_i[idx[WAY_W-1:0]] < best_sh) begin
        best    = idx[WAY_W-1:0];
        best_sh = s_i[idx[WAY_W-1:0]];
      end
    end
    ev_way_o = best;
  end

endmodule
`default_nettype wire

>>> sv/sasf_victim_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sasf_victim_list
// Packed victim list in insertion order: search from the oldest entry,
// append, sharer update and release with compaction.
// ----------------------------------------------------------------------------
module sasf_victim_list #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire  [sasf_pkg::ADDR_W-1:0]   addr_i,
  input  wire  sasf_pkg::sasf_vic_cmd_t cmd_i,
  output sasf_pkg::sasf_vic_sts_t       sts_o
);
  import sasf_pkg::*;

  logic [DEPTH-1:0]             vv_q;
  logic [DEPTH-1:0][ADDR_W-1:0] va_q;
  logic [DEPTH-1:0][SH_W-1:0]   vs_q;

  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] first;
  logic [DEPTH-1:0] tail;
  logic [DEPTH-1:0] slot;

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = vv_q[i] && (va_q[i] == addr_i);
      first[i] = match[i] && !seen;
      seen     = seen | match[i];
      tail[i]  = seen;
      slot[i]  = !vv_q[i] && ((i == 0) || vv_q[(i == 0) ? 0 : i - 1]);
    end
  end

  assign sts_o.found = |match;
  assign sts_o.full  = vv_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vv_q <= '0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (cmd_i.push && slot[i]) begin
          vv_q[i] <= 1'b1;
        end else if (cmd_i.rel && tail[i]) begin
          vv_q[i] <= (i + 1 < DEPTH) ? vv_q[(i + 1 < DEPTH) ? i + 1 : i] : 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.push && slot[i]) begin
        va_q[i] <= cmd_i.push_addr;
        vs_q[i] <= cmd_i.push_sh;
      end else if (cmd_i.upd && first[i]) begin
        vs_q[i] <= cmd_i.upd_sh;
      end else if (cmd_i.rel && tail[i] && (i + 1 < DEPTH)) begin
        va_q[i] <= va_q[(i + 1 < DEPTH) ? i + 1 : i];
        vs_q[i] <= vs_q[(i + 1 < DEPTH) ? i + 1 : i];
      end
    end
  end

  // list must stay packed from the bottom
  a_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vv_q + 1'b1) & vv_q) == '0)
    else $error("victim list not packed");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !vv_q[DEPTH-1])
    else $error("push into full victim list");

  a_rel_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rel || cmd_i.upd) |-> (|match))
    else $error("victim change without a matching entry");

endmodule
`default_nettype wire

>>> sv/set_assoc_snoop_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_snoop_filter
// Set-associative snoop filter directory with a bounded victim list.
// Path: set read into the memory read register, then compare and
//   write-back into the output register; longer while the response stalls.
// Pacing: a new request is taken only after the one in flight writes back,
//   set by the read-modify-write of the directory row memory.
// Reset: rows, pointers and victim list read as empty at once; no clear pass.
// ----------------------------------------------------------------------------
module set_assoc_snoop_filter #(
  parameter int unsigned WAYS         = 8,
  parameter int unsigned SETS         = 128,
  parameter int unsigned VICTIM_DEPTH = 16,
  parameter int unsigned MAX_SHARERS  = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  sasf_cfg_if.sink   cfg_i,
  sasf_req_if.sink   req_i,
  sasf_rsp_if.source rsp_o
);
  import sasf_pkg::*;

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam logic [SH_W-1:0] MAX_SH = SH_W'(MAX_SHARERS);

  sasf_fsm_e state_q, state_d;

  logic [OFS_W-1:0]  ofs_q;
  sasf_op_e          op_q;
  logic [ADDR_W-1:0] addr_q;
  logic              region_q;
  logic [SH_W-1:0]   cnt_q;
  logic [SET_W-1:0]  set_q;

  logic                out_vld_q;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [WAY_O_W-1:0]  out_way_q, out_way_d;
  logic [ADDR_W-1:0]   out_ev_addr_q, out_ev_addr_d;
  logic [SH_W-1:0]     out_ev_sh_q, out_ev_sh_d;

  logic              accept;
  logic              fire;
  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  req_set;
  logic [SH_W-1:0]   req_cnt;

  logic [WAYS-1:0]             rd_v, wr_v;
  logic [WAYS-1:0][ADDR_W-1:0] rd_a, wr_a;
  logic [WAYS-1:0][SH_W-1:0]   rd_s, wr_s;
  logic [WAY_W-1:0]            rd_p, wr_p;

  logic             hit, free;
  logic [WAY_W-1:0] hit_way, free_way, ev_way;

  sasf_vic_cmd_t vic_cmd;
  sasf_vic_sts_t vic_sts;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == FSM_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign fire        = (state_q == FSM_EXEC) && (!out_vld_q || rsp_o.ready);

  assign shifted = req_i.address >> ofs_q;
  assign req_set = (SETS > 1) ? shifted[SET_W-1:0] : '0;
  assign req_cnt = (req_i.sharer_count > MAX_SH) ? MAX_SH : req_i.sharer_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      ofs_q     <= OFS_RESET;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        ofs_q <= cfg_i.data;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= sasf_op_e'(req_i.operation);
      addr_q   <= req_i.address;
      region_q <= req_i.in_coherent_region;
      cnt_q    <= req_cnt;
      set_q    <= req_set;
    end
    if (fire) begin
      out_status_q  <= out_status_d;
      out_way_q     <= out_way_d;
      out_ev_addr_q <= out_ev_addr_d;
      out_ev_sh_q   <= out_ev_sh_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (accept) state_d = FSM_EXEC;
      FSM_EXEC: if (fire)   state_d = FSM_IDLE;
      default:              state_d = FSM_IDLE;
    endcase
  end

  sasf_dir_mem #(
    .WAYS  (WAYS),
    .SETS  (SETS),
    .WAY_W (WAY_W),
    .SET_W (SET_W)
  ) u_dir_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_set_i (req_set),
    .rd_v_o   (rd_v),
    .rd_a_o   (rd_a),
    .rd_s_o   (rd_s),
    .rd_p_o   (rd_p),
    .wr_en_i  (fire),
    .wr_set_i (set_q),
    .wr_v_i   (wr_v),
    .wr_a_i   (wr_a),
    .wr_s_i   (wr_s),
    .wr_p_i   (wr_p)
  );

  sasf_way_sel #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W)
  ) u_way_sel (
    .v_i        (rd_v),
    .a_i        (rd_a),
    .s_i        (rd_s),
    .ptr_i      (rd_p),
    .addr_i     (addr_q),
    .hit_o      (hit),
    .hit_way_o  (hit_way),
    .free_o     (free),
    .free_way_o (free_way),
    .ev_way_o   (ev_way)
  );

  sasf_victim_list #(
    .DEPTH (VICTIM_DEPTH)
  ) u_victim (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .addr_i (addr_q),
    .cmd_i  (vic_cmd),
    .sts_o  (vic_sts)
  );

  // Row update and response for the request in flight
  always_comb begin
    wr_v          = rd_v;
    wr_a          = rd_a;
    wr_s          = rd_s;
    wr_p          = rd_p;
    vic_cmd       = '0;
    out_status_d  = ST_MISS;
    out_way_d     = '0;
    out_ev_addr_d = '0;
    out_ev_sh_d   = '0;
    case (op_q)
      OP_LOOKUP, OP_ALLOC: begin
        if ((op_q == OP_ALLOC) && !region_q) begin
          out_status_d = ST_UNTRACKED;
        end else if (hit) begin
          out_status_d = ST_HIT;
          out_way_d    = WAY_O_W'(hit_way);
        end else if (free) begin
          wr_v[free_way] = 1'b1;
          wr_a[free_way] = addr_q;
          wr_s[free_way] = '0;
          out_status_d   = ST_FILLED;
          out_way_d      = WAY_O_W'(free_way);
        end else if (vic_sts.found) begin
          out_status_d = ST_VICTIM_HIT;
        end else if (op_q == OP_ALLOC) begin
          if (vic_sts.full) begin
            out_status_d = ST_VICTIM_FULL;
          end else begin
            vic_cmd.push      = fire;
            vic_cmd.push_addr = rd_a[ev_way];
            vic_cmd.push_sh   = rd_s[ev_way];
            wr_a[ev_way]      = addr_q;
            wr_s[ev_way]      = '0;
            wr_p              = (rd_p == WAY_W'(WAYS - 1)) ? '0 : rd_p + 1'b1;
            out_status_d      = ST_EVICTED;
            out_way_d         = WAY_O_W'(ev_way);
            out_ev_addr_d     = rd_a[ev_way];
            out_ev_sh_d       = rd_s[ev_way];
          end
        end
      end
      OP_SET_CNT: begin
        if (hit) begin
          wr_s[hit_way] = cnt_q;
          out_status_d  = ST_UPDATED;
          out_way_d     = WAY_O_W'(hit_way);
        end else if (vic_sts.found) begin
          vic_cmd.upd    = fire;
          vic_cmd.upd_sh = cnt_q;
          out_status_d   = ST_UPDATED;
        end else begin
          out_status_d = ST_UPD_MISSING;
        end
      end
      OP_RELEASE: begin
        if (vic_sts.found) begin
          vic_cmd.rel  = fire;
          out_status_d = ST_RELEASED;
        end else begin
          out_status_d = ST_REL_MISSING;
        end
      end
      default: out_status_d = ST_MISS;
    endcase
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.way             = out_way_q;
  assign rsp_o.evicted_address = out_ev_addr_q;
  assign rsp_o.evicted_sharers = out_ev_sh_q;

  a_rsp_from_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == FSM_EXEC))
    else $error("response raised without an executing request");

  a_fire_returns_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (state_q == FSM_IDLE))
    else $error("state did not return to idle after execute");

  a_hold_while_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == FSM_EXEC) && out_vld_q && !rsp_o.ready) |=> (state_q == FSM_EXEC))
    else $error("request dropped while response stalled");

endmodule
`default_nettype wire

>>> sim/sasf_filter_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sasf_filter_checker
// Watches the configuration, request and response channels of the snoop
// filter, keeps its own copy of the directory and victim list, predicts the
// response to every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module sasf_filter_checker
  import sasf_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  sasf_cfg_if   cfg_i,
  sasf_req_if   req_i,
  sasf_rsp_if   rsp_i,
  output int    errors_o,
  output int    pending_o,
  output int    evictions_o
);

  localparam int NWAYS  = 8;
  localparam int NSETS  = 128;
  localparam int VDEPTH = 16;
  localparam int SH_MAX = 64;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WAY_O_W-1:0]  way;
    logic [ADDR_W-1:0]   ev_addr;
    logic [SH_W-1:0]     ev_sh;
  } filter_rsp_t;

  filter_rsp_t       expected_rsp[$];
  logic [OFS_W-1:0]  ofs;
  logic              dir_v  [NWAYS*NSETS];
  logic [ADDR_W-1:0] dir_a  [NWAYS*NSETS];
  logic [SH_W-1:0]   dir_sh [NWAYS*NSETS];
  logic [2:0]        rr_ptr [NSETS];
  logic              vic_v  [VDEPTH];
  logic [ADDR_W-1:0] vic_a  [VDEPTH];
  logic [SH_W-1:0]   vic_sh [VDEPTH];

  assign pending_o = expected_rsp.size();

  task automatic report(string what, longint got, longint want);
    $display("[%0t] response %s: got %0d, expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  function automatic filter_rsp_t filter_next(sasf_op_e op, logic [ADDR_W-1:0] a,
                                              logic region, logic [SH_W-1:0] cnt_in);
    filter_rsp_t r;
    int set, base, hit, free_w, vi, n, ptr, best, w;
    logic [SH_W-1:0] cnt;
    r = '0;
    r.status = ST_MISS;
    cnt = (cnt_in > SH_MAX) ? SH_W'(SH_MAX) : cnt_in;
    set = int'((a >> ofs) & (NSETS - 1));
    base = set * NWAYS;
    hit = -1;
    free_w = -1;
    vi = -1;
    for (w = 0; w < NWAYS; w++) begin
      if (hit < 0 && dir_v[base+w] && dir_a[base+w] == a) hit = w;
      if (free_w < 0 && !dir_v[base+w]) free_w = w;
    end
    for (w = 0; w < VDEPTH; w++)
      if (vi < 0 && vic_v[w] && vic_a[w] == a) vi = w;
    case (op)
      OP_LOOKUP, OP_ALLOC: begin
        if (op == OP_ALLOC && !region) begin
          r.status = ST_UNTRACKED;
        end else if (hit >= 0) begin
          r.status = ST_HIT;
          r.way = WAY_O_W'(hit);
        end else if (free_w >= 0) begin
          dir_v[base+free_w] = 1'b1;
          dir_a[base+free_w] = a;
          dir_sh[base+free_w] = '0;
          r.status = ST_FILLED;
          r.way = WAY_O_W'(free_w);
        end else if (vi >= 0) begin
          r.status = ST_VICTIM_HIT;
        end else if (op == OP_ALLOC) begin
          n = 0;
          while (n < VDEPTH && vic_v[n]) n++;
          if (n >= VDEPTH) begin
            r.status = ST_VICTIM_FULL;
          end else begin
            // fewest sharers, first minimum from the round-robin pointer
            ptr = rr_ptr[set];
            best = ptr;
            for (w = 1; w < NWAYS; w++)
              if (dir_sh[base+((ptr+w)%NWAYS)] < dir_sh[base+best]) best = (ptr + w) % NWAYS;
            rr_ptr[set] = 3'((ptr + 1) % NWAYS);
            r.ev_addr = dir_a[base+best];
            r.ev_sh = dir_sh[base+best];
            vic_v[n] = 1'b1;
            vic_a[n] = r.ev_addr;
            vic_sh[n] = r.ev_sh;
            dir_a[base+best] = a;
            dir_sh[base+best] = '0;
            r.status = ST_EVICTED;
            r.way = WAY_O_W'(best);
          end
        end
      end
      OP_SET_CNT: begin
        if (hit >= 0) begin
          dir_sh[base+hit] = cnt;
          r.way = WAY_O_W'(hit);
          r.status = ST_UPDATED;
        end else if (vi >= 0) begin
          vic_sh[vi] = cnt;
          r.status = ST_UPDATED;
        end else begin
          r.status = ST_UPD_MISSING;
        end
      end
      default: begin
        if (vi < 0) begin
          r.status = ST_REL_MISSING;
        end else begin
          for (w = vi; w + 1 < VDEPTH; w++) begin
            vic_v[w] = vic_v[w+1];
            vic_a[w] = vic_a[w+1];
            vic_sh[w] = vic_sh[w+1];
          end
          vic_v[VDEPTH-1] = 1'b0;
          r.status = ST_RELEASED;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filter_rsp_t want;
    if (!rst_ni) begin
      ofs = OFS_RESET;
      for (int i = 0; i < NWAYS*NSETS; i++) begin
        dir_v[i] = 1'b0;
        dir_a[i] = '0;
        dir_sh[i] = '0;
      end
      for (int i = 0; i < NSETS; i++) rr_ptr[i] = '0;
      for (int i = 0; i < VDEPTH; i++) begin
        vic_v[i] = 1'b0;
        vic_a[i] = '0;
        vic_sh[i] = '0;
      end
      expected_rsp.delete();
      errors_o = 0;
      evictions_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) ofs = cfg_i.data;
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_rsp.size() == 0) begin
          report("with no request outstanding", rsp_i.status, -1);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_i.status !== want.status) report("status", rsp_i.status, want.status);
          if (rsp_i.way !== want.way) report("way", rsp_i.way, want.way);
          if (rsp_i.evicted_address !== want.ev_addr)
            report("evicted_address", rsp_i.evicted_address, want.ev_addr);
          if (rsp_i.evicted_sharers !== want.ev_sh)
            report("evicted_sharers", rsp_i.evicted_sharers, want.ev_sh);
          if (want.status == ST_EVICTED) evictions_o++;
        end
      end
      if (req_i.valid && req_i.ready)
        expected_rsp.insert(expected_rsp.size(),
                            filter_next(sasf_op_e'(req_i.operation), req_i.address,
                                        req_i.in_coherent_region, req_i.sharer_count));
    end
  end

endmodule
`default_nettype wire

>>> sim/tb_set_assoc_snoop_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_set_assoc_snoop_filter
// Drives directed and random directory requests into the snoop filter under
// several block offset settings, with bursty requests and a stalling
// response side; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_set_assoc_snoop_filter;
  import sasf_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sasf_cfg_if cfg ();
  sasf_req_if req ();
  sasf_rsp_if rsp ();

  int errors, pending, evictions;
  int cyc = 0;
  int hold_cyc = 0;
  int idle_cyc = 0;
  int sent = 0;
  int burst_left = 0;
  logic [OFS_W-1:0] cur_ofs = OFS_RESET;

  set_assoc_snoop_filter dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .req_i (req),
    .rsp_o (rsp)
  );

  sasf_filter_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .req_i      (req),
    .rsp_i      (rsp),
    .errors_o   (errors),
    .pending_o  (pending),
    .evictions_o(evictions)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // response side: changing stall pattern, plus one long hold-off
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (sent >= 200 && hold_cyc < 300) begin
      hold_cyc  <= hold_cyc + 1;
      rsp.ready <= 1'b0;
    end else begin
      case ((cyc / 97) % 3)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(0, 3) != 0);
        default: rsp.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_req(sasf_op_e op, logic [ADDR_W-1:0] a, logic region,
                          logic [SH_W-1:0] cnt);
    int gap;
    req.valid <= 1'b1;
    req.operation <= op;
    req.address <= a;
    req.in_coherent_region <= region;
    req.sharer_count <= cnt;
    do @(posedge clk_i); while (!req.ready);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_and_configure(logic [OFS_W-1:0] v);
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    cur_ofs = v;
  endtask

  // addresses crowd a few sets so that ways fill and the victim list works
  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [ADDR_W-1:0] tag, set;
    if ($urandom_range(0, 99) < 8) return ADDR_W'({$urandom, $urandom});
    tag = ADDR_W'($urandom_range(0, 11));
    set = ADDR_W'($urandom_range(0, 2));
    return (tag << (cur_ofs + 7)) | (set << cur_ofs);
  endfunction

  task automatic random_phase(int n);
    int r;
    sasf_op_e op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      op = (r < 25) ? OP_LOOKUP : (r < 65) ? OP_ALLOC : (r < 85) ? OP_SET_CNT : OP_RELEASE;
      send_req(op, pick_addr(), ($urandom_range(0, 9) != 0), SH_W'($urandom_range(0, 127)));
      if (i == n / 2 && n > 100) begin
        // sender waits for every outstanding response
        req.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] a;
    req.valid <= 1'b0;
    req.operation <= OP_LOOKUP;
    req.address <= '0;
    req.in_coherent_region <= 1'b0;
    req.sharer_count <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every operation, region off, saturation, full set
    send_req(OP_LOOKUP, '0, 1'b0, '0);
    send_req(OP_ALLOC, '1, 1'b1, 7'd127);
    send_req(OP_ALLOC, 48'h1234, 1'b0, '0);
    send_req(OP_SET_CNT, '1, 1'b0, 7'd127);
    send_req(OP_SET_CNT, 48'hdead_0000, 1'b0, 7'd3);
    send_req(OP_RELEASE, 48'h5555_5555_5555, 1'b1, '0);
    for (int t = 1; t <= 9; t++) begin
      a = ADDR_W'(t) << 13;
      send_req(OP_ALLOC, a, 1'b1, '0);
      if (t <= 4) send_req(OP_SET_CNT, a, 1'b0, SH_W'(65 - t));
    end
    send_req(OP_LOOKUP, ADDR_W'(10) << 13, 1'b1, '0);
    send_req(OP_SET_CNT, ADDR_W'(5) << 13, 1'b0, 7'd64);
    send_req(OP_RELEASE, ADDR_W'(5) << 13, 1'b0, '0);
    send_req(OP_LOOKUP, 48'haaaa_aaaa_aaaa, 1'b0, 7'h55);

    random_phase(110);
    drain_and_configure(4'd12);
    random_phase(110);
    drain_and_configure(4'd0);
    random_phase(110);
    drain_and_configure(4'd9);
    random_phase(110);

    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("covered %0d requests, %0d evictions, block offsets 6, 12, 0 and 9",
             sent, evictions);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
